>>> rtl/nsv_pkg.sv
package nsv_pkg;

   localparam int unsigned PhaseWidth = 2;
   localparam logic [PhaseWidth-1:0] PH_IDLE = 2'd0;
   localparam logic [PhaseWidth-1:0] PH_BODY = 2'd1;
   localparam logic [PhaseWidth-1:0] PH_HEX1 = 2'd2;
   localparam logic [PhaseWidth-1:0] PH_HEX2 = 2'd3;

   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_UNKNOWN  = 3'd1;
   localparam logic [2:0] CAUSE_MISMATCH = 3'd2;
   localparam logic [2:0] CAUSE_BADHEX   = 3'd3;
   localparam logic [2:0] CAUSE_OVERLONG = 3'd4;

   localparam logic [1:0] KIND_INVALID = 2'd0;
   localparam logic [1:0] KIND_GLL     = 2'd1;
   localparam logic [1:0] KIND_GSA     = 2'd2;
   localparam logic [1:0] KIND_ZDA     = 2'd3;

   localparam logic [23:0] TYPE_GLL = 24'h474C4C;
   localparam logic [23:0] TYPE_GSA = 24'h475341;
   localparam logic [23:0] TYPE_ZDA = 24'h5A4441;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;

   localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;

   localparam logic [1:0] ADDR_MAX_LENGTH = 2'd0;

   typedef struct packed {
      logic [1:0] sentence_kind;
      logic [2:0] error_cause;
      logic [7:0] computed_checksum;
      logic [7:0] received_checksum;
   } nsv_result_type;

   // Returns {digit_ok, nibble}; a character that is not a hex digit gives nibble zero.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [7:0] d;
      logic [4:0] r;
      d = 8'd0;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d = b - 8'd48;
         r = {1'b1, d[3:0]};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d = b - 8'd87;
         r = {1'b1, d[3:0]};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d = b - 8'd55;
         r = {1'b1, d[3:0]};
      end
      return r;
   endfunction

endpackage

>>> rtl/nsv_core.sv
module nsv_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  logic [7:0]              data_byte,
   input  logic [7:0]              max_length,
   output logic                    result_valid,
   output nsv_pkg::nsv_result_type result
);
   import nsv_pkg::*;

   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [7:0]            position_ff, position_in;
   logic [7:0]            xor_ff, xor_in;
   logic [23:0]           type_ff, type_in;
   logic [3:0]            high_ff, high_in;
   logic                  hex_error_ff, hex_error_in;

   logic [4:0] hex;
   logic [7:0] rx;
   logic [1:0] kind;
   logic [2:0] cause;

   assign hex = hex_decode(data_byte);
   assign rx  = {high_ff, hex[3:0]};

   always_comb begin
      priority if (type_ff == TYPE_GLL) begin
         kind = KIND_GLL;
      end else if (type_ff == TYPE_GSA) begin
         kind = KIND_GSA;
      end else if (type_ff == TYPE_ZDA) begin
         kind = KIND_ZDA;
      end else begin
         kind = KIND_INVALID;
      end
      priority if (kind == KIND_INVALID) begin
         cause = CAUSE_UNKNOWN;
      end else if (hex_error_ff || !hex[4]) begin
         cause = CAUSE_BADHEX;
      end else if (rx != xor_ff) begin
         cause = CAUSE_MISMATCH;
      end else begin
         cause = CAUSE_NONE;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      position_in  = position_ff;
      xor_in       = xor_ff;
      type_in      = type_ff;
      high_in      = high_ff;
      hex_error_in = hex_error_ff;
      result_valid = 1'b0;
      result       = '0;
      result.computed_checksum = xor_ff;
      if (byte_valid) begin
         if (data_byte == CHAR_DOLLAR) begin
            phase_in     = PH_BODY;
            position_in  = 8'd0;
            xor_in       = 8'd0;
            type_in      = 24'd0;
            high_in      = 4'd0;
            hex_error_in = 1'b0;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
               end
               PH_BODY: begin
                  if (data_byte == CHAR_STAR) begin
                     phase_in = PH_HEX1;
                  end else if (position_ff >= max_length) begin
                     phase_in           = PH_IDLE;
                     result_valid       = 1'b1;
                     result.error_cause = CAUSE_OVERLONG;
                  end else begin
                     xor_in = xor_ff ^ data_byte;
                     if (position_ff >= 8'd2 && position_ff <= 8'd4) begin
                        type_in = {type_ff[15:0], data_byte};
                     end
                     position_in = position_ff + 8'd1;
                  end
               end
               PH_HEX1: begin
                  high_in      = hex[3:0];
                  hex_error_in = !hex[4];
                  phase_in     = PH_HEX2;
               end
               PH_HEX2: begin
                  phase_in     = PH_IDLE;
                  hex_error_in = hex_error_ff || !hex[4];
                  result_valid = 1'b1;
                  result.sentence_kind     = (cause == CAUSE_NONE) ? kind : KIND_INVALID;
                  result.error_cause       = cause;
                  result.received_checksum = rx;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         position_ff  <= 8'd0;
         xor_ff       <= 8'd0;
         type_ff      <= 24'd0;
         high_ff      <= 4'd0;
         hex_error_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         position_ff  <= position_in;
         xor_ff       <= xor_in;
         type_ff      <= type_in;
         high_ff      <= high_in;
         hex_error_ff <= hex_error_in;
      end
   end

endmodule

>>> rtl/nsv_out.sv
module nsv_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    result_valid,
   input  nsv_pkg::nsv_result_type result,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output nsv_pkg::nsv_result_type rsp_result
);
   import nsv_pkg::*;

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   nsv_result_type out_ff, out_in;
   nsv_result_type skid_ff, skid_in;
   logic           take;

   assign take       = out_valid_ff && !rsp_stall;
   assign full       = skid_valid_ff;
   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_in       = result;
         out_valid_in = result_valid;
      end else if (result_valid) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

>>> rtl/nmea_sentence_validator.sv
// NMEA 0183 sentence checker. It takes one received byte per transaction and gives one
// verdict for each sentence that opens with '$' and ends in '*' and two bytes or runs
// over the length limit: the type (GLL, GSA or ZDA), an error cause, the XOR of the body
// bytes and the two-digit checksum that followed '*'. A byte is taken in every cycle while
// req_stall is low; a two-entry output buffer lets bytes keep flowing while one verdict
// waits, and req_stall rises only once both entries are held. max_sentence_length sits at
// address 0 of the register port and is to be written only while no verdict is pending.
module nmea_sentence_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_sentence_kind,
   output logic [2:0]  rsp_error_cause,
   output logic [7:0]  rsp_computed_checksum,
   output logic [7:0]  rsp_received_checksum,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import nsv_pkg::*;

   logic [7:0]     max_length_ff;
   logic           accept;
   logic           core_valid;
   nsv_result_type core_result;
   nsv_result_type out_result;

   assign pready = 1'b1;
   assign prdata = {24'd0, max_length_ff};
   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (psel && penable && pwrite && paddr == ADDR_MAX_LENGTH) begin
         max_length_ff <= pwdata[7:0];
      end
   end

   nsv_core u_core (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (accept),
      .data_byte    (req_data_byte),
      .max_length   (max_length_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   nsv_out u_out (
      .clock        (clock),
      .reset        (reset),
      .result_valid (core_valid),
      .result       (core_result),
      .full         (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (out_result)
   );

   assign rsp_sentence_kind     = out_result.sentence_kind;
   assign rsp_error_cause       = out_result.error_cause;
   assign rsp_computed_checksum = out_result.computed_checksum;
   assign rsp_received_checksum = out_result.received_checksum;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import nsv_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;

   localparam int STALL_NONE = 0;
   localparam int STALL_LIGHT = 1;
   localparam int STALL_HEAVY = 2;
   localparam int STALL_TOGGLE = 3;

   localparam int FLAW_NONE = 0;
   localparam int FLAW_WRONG_SUM = 1;
   localparam int FLAW_BAD_DIGIT = 2;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_sentence_kind;
   logic [2:0]  rsp_error_cause;
   logic [7:0]  rsp_computed_checksum;
   logic [7:0]  rsp_received_checksum;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = 2'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   nmea_sentence_validator u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_sentence_kind     (rsp_sentence_kind),
      .rsp_error_cause       (rsp_error_cause),
      .rsp_computed_checksum (rsp_computed_checksum),
      .rsp_received_checksum (rsp_received_checksum),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted state of the sentence parser.
   logic [PhaseWidth-1:0] sent_phase = PH_IDLE;
   logic [7:0]  body_count = 8'd0;
   logic [7:0]  body_xor = 8'd0;
   logic [23:0] type_tag = 24'd0;
   logic [3:0]  hex_high = 4'd0;
   logic        hex_bad = 1'b0;
   logic [7:0]  length_limit = MAX_LENGTH_RESET;

   logic [7:0]     pending_bytes[$];
   nsv_result_type pending_verdicts[$];

   int queued_total = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = STALL_NONE;
   int mode_left = 0;
   int hold_cycles_left = 0;
   bit long_hold_go = 1'b0;

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") begin
         return {1'b1, c[3:0]};
      end
      if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
         return {1'b1, c[3:0] + 4'd9};
      end
      return 5'd0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) begin
         return 8'h30 + n;
      end
      return (lower ? 8'h57 : 8'h37) + n;
   endfunction

   function automatic logic [7:0] body_char();
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 3) == 0) begin
            c = 8'($urandom_range(0, 255));
         end else begin
            c = 8'($urandom_range(8'h20, 8'h7E));
         end
      end while (c == CHAR_DOLLAR || c == CHAR_STAR);
      return c;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0: c = 8'h00;
         1: c = CHAR_STAR;
         default: begin
            do begin
               c = 8'($urandom_range(0, 255));
            end while (nibble_of(c) >= 5'h10 || c == CHAR_DOLLAR);
         end
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   task automatic add_verdict(input logic [1:0] kind, input logic [2:0] cause,
                              input logic [7:0] received);
      nsv_result_type v;
      v.sentence_kind = kind;
      v.error_cause = cause;
      v.computed_checksum = body_xor;
      v.received_checksum = received;
      pending_verdicts.push_back(v);
   endtask

   task automatic advance_sentence(input logic [7:0] b);
      logic [4:0] digit;
      logic [7:0] received;
      logic [1:0] kind;
      logic [2:0] cause;
      if (b == CHAR_DOLLAR) begin
         sent_phase = PH_BODY;
         body_count = 8'd0;
         body_xor = 8'd0;
         type_tag = 24'd0;
         hex_high = 4'd0;
         hex_bad = 1'b0;
      end else begin
         case (sent_phase)
            PH_BODY: begin
               if (b == CHAR_STAR) begin
                  sent_phase = PH_HEX1;
               end else if (body_count >= length_limit) begin
                  add_verdict(KIND_INVALID, CAUSE_OVERLONG, 8'd0);
                  sent_phase = PH_IDLE;
               end else begin
                  body_xor = body_xor ^ b;
                  if (body_count >= 8'd2 && body_count <= 8'd4) begin
                     type_tag = {type_tag[15:0], b};
                  end
                  body_count = body_count + 8'd1;
               end
            end
            PH_HEX1: begin
               digit = nibble_of(b);
               hex_high = digit[3:0];
               hex_bad = !digit[4];
               sent_phase = PH_HEX2;
            end
            PH_HEX2: begin
               digit = nibble_of(b);
               if (!digit[4]) begin
                  hex_bad = 1'b1;
               end
               received = {hex_high, digit[3:0]};
               sent_phase = PH_IDLE;
               if (type_tag == TYPE_GLL) begin
                  kind = KIND_GLL;
               end else if (type_tag == TYPE_GSA) begin
                  kind = KIND_GSA;
               end else if (type_tag == TYPE_ZDA) begin
                  kind = KIND_ZDA;
               end else begin
                  kind = KIND_INVALID;
               end
               if (kind == KIND_INVALID) begin
                  cause = CAUSE_UNKNOWN;
               end else if (hex_bad) begin
                  cause = CAUSE_BADHEX;
               end else if (received != body_xor) begin
                  cause = CAUSE_MISMATCH;
               end else begin
                  cause = CAUSE_NONE;
               end
               add_verdict((cause == CAUSE_NONE) ? kind : KIND_INVALID, cause, received);
            end
            default: begin
               sent_phase = PH_IDLE;
            end
         endcase
      end
   endtask

   // Byte sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall !== 1'b0)) begin
         if (req_valid) begin
            advance_sentence(req_data_byte);
            void'(pending_bytes.pop_front());
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_valid <= 1'b1;
            req_data_byte <= pending_bytes[0];
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                        : $urandom_range(0, 15);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Verdict receiver stall pattern, with one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles_left > 0) begin
         hold_cycles_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_go) begin
         long_hold_go = 1'b0;
         hold_cycles_left = LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_TOGGLE);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= !rsp_stall;
         endcase
      end
   end

   // Verdict checker.
   always @(posedge clock) begin
      nsv_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("unexpected verdict kind %0d cause %0d",
                                      rsp_sentence_kind, rsp_error_cause));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_sentence_kind !== want.sentence_kind ||
                rsp_error_cause !== want.error_cause ||
                rsp_computed_checksum !== want.computed_checksum ||
                rsp_received_checksum !== want.received_checksum) begin
               report_mismatch($sformatf(
                  "verdict expected kind %0d cause %0d sum %h rx %h, got %0d %0d %h %h",
                  want.sentence_kind, want.error_cause, want.computed_checksum,
                  want.received_checksum, rsp_sentence_kind, rsp_error_cause,
                  rsp_computed_checksum, rsp_received_checksum));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      queued_total++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(s[i]);
      end
   endtask

   task automatic queue_sentence(input logic [23:0] tag, input int field_count,
                                 input int flaw);
      logic [7:0] sum;
      logic [7:0] sent_sum;
      logic [7:0] c;
      int bad_pos;
      sum = 8'd0;
      bad_pos = $urandom_range(0, 1);
      queue_byte(CHAR_DOLLAR);
      repeat (2) begin
         c = 8'($urandom_range("A", "Z"));
         queue_byte(c);
         sum = sum ^ c;
      end
      for (int i = 0; i < 3; i++) begin
         c = tag[23 - 8 * i -: 8];
         queue_byte(c);
         sum = sum ^ c;
      end
      repeat (field_count) begin
         c = body_char();
         queue_byte(c);
         sum = sum ^ c;
      end
      queue_byte(CHAR_STAR);
      sent_sum = (flaw == FLAW_WRONG_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < 2; i++) begin
         if (flaw == FLAW_BAD_DIGIT && i == bad_pos) begin
            queue_byte(non_hex_char());
         end else begin
            queue_byte(hex_char(i == 0 ? sent_sum[7:4] : sent_sum[3:0],
                                1'($urandom_range(0, 1))));
         end
      end
      if ($urandom_range(0, 1)) begin
         queue_byte(8'h0D);
         queue_byte(8'h0A);
      end
   endtask

   task automatic random_traffic(input int byte_budget);
      int stop_at;
      int field_count;
      int flaw;
      int roll;
      logic [23:0] tag;
      stop_at = queued_total + byte_budget;
      while (queued_total < stop_at) begin
         roll = $urandom_range(0, 9);
         if (roll < 8) begin
            case ($urandom_range(0, 4))
               0: tag = TYPE_GLL;
               1: tag = TYPE_GSA;
               2: tag = TYPE_ZDA;
               3: tag = {8'($urandom_range("A", "Z")), 8'($urandom_range("A", "Z")),
                         8'($urandom_range("A", "Z"))};
               default: begin
                  case ($urandom_range(0, 2))
                     0: tag = TYPE_GLL;
                     1: tag = TYPE_GSA;
                     default: tag = TYPE_ZDA;
                  endcase
                  tag = tag ^ (24'd1 << $urandom_range(0, 23));
               end
            endcase
            case ($urandom_range(0, 9))
               0: field_count = int'(length_limit) - 6 + $urandom_range(0, 2);
               1: field_count = $urandom_range(0, int'(length_limit) + 3);
               default: field_count = $urandom_range(0, 12);
            endcase
            if (field_count < 0) begin
               field_count = 0;
            end
            roll = $urandom_range(0, 9);
            flaw = (roll < 6) ? FLAW_NONE : (roll < 8) ? FLAW_WRONG_SUM : FLAW_BAD_DIGIT;
            queue_sentence(tag, field_count, flaw);
         end else if (roll == 8) begin
            repeat ($urandom_range(1, 6)) begin
               queue_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            queue_byte(CHAR_DOLLAR);
            repeat ($urandom_range(0, 6)) begin
               queue_byte(body_char());
            end
            if ($urandom_range(0, 1)) begin
               queue_byte(CHAR_STAR);
               repeat ($urandom_range(0, 2)) begin
                  queue_byte(8'($urandom_range(0, 255)));
               end
            end
         end
      end
   endtask

   task automatic write_max_length(input logic [7:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_MAX_LENGTH;
      pwdata <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      length_limit = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[7:0] !== value) begin
         report_mismatch($sformatf("max_sentence_length read %h, expected %h",
                                   prdata[7:0], value));
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || pending_verdicts.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_max_length(8'd8);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CHAR_STAR);
      queue_text("$GPGLL*50");
      queue_text("$GP$GNGLL*4e");
      queue_text("$GPZDA*48");
      queue_text("$GPGSA*43");
      queue_text("$GP*");
      queue_byte(8'h00);
      queue_byte(CHAR_STAR);
      queue_text("$GPGLL*G0");
      queue_text("$GPZDA,123*00");
      queue_text("$GPGLL*5$GNGSA*5C");
      drain();

      write_max_length(MAX_LENGTH_RESET);
      long_hold_go = 1'b1;
      random_traffic(400);
      drain();

      write_max_length(8'd255);
      random_traffic(250);
      drain();

      write_max_length(8'd8);
      random_traffic(250);
      drain();

      write_max_length(8'($urandom_range(9, 254)));
      random_traffic(250);
      drain();

      write_max_length(8'($urandom_range(0, 7)));
      random_traffic(100);
      drain();

      write_max_length(8'($urandom_range(20, 120)));
      random_traffic(200);
      drain();

      if (pending_verdicts.size() != 0) begin
         report_mismatch("verdicts still outstanding at the end");
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
